/* hw/rtl/rlsfe_pkg.sv */
// ----------------------------------------------------------------------------
// RGB LED strip frame encoder package
// Shared constants, the queue entry type and the scaling helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rlsfe_pkg;

  localparam int MAX_LEDS  = 512;
  localparam int LEN_W     = 10;
  localparam int POS_W     = 9;
  localparam int FILL_W    = 6;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BRIGHTNESS = 2'd2;

  localparam logic [7:0] HEADER_MARK = 8'hE0;
  localparam logic [7:0] BRIGHT_MAX  = 8'd31;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;
  localparam logic [1:0] START_LAST  = 2'd3;

  typedef struct packed {
    logic              start;
    logic [FILL_W-1:0] fill_count;
    logic [7:0]        header;
    logic [15:0]       prod_blue;
    logic [15:0]       prod_green;
    logic [15:0]       prod_red;
  } desc_t;

  // Exact truncating division by 255 for any 16-bit product up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rlsfe_pixel_if.sv */
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one pixel item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlsfe_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rlsfe_byte_if.sv */
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel carrying one serial byte item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlsfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] serial_byte;
  logic       last_of_run;

  modport source (output valid, output serial_byte, output last_of_run, input ready);
  modport sink   (input valid, input serial_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rlsfe_front.sv */
// ----------------------------------------------------------------------------
// Frame encoder front end
// Holds the configuration, tracks the frame position and classifies each
// pixel into a queue entry with its colour products.
// ----------------------------------------------------------------------------
`default_nettype none

module rlsfe_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rlsfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rlsfe_pkg::CFG_W-1:0]    cfg_data,
  rlsfe_pixel_if.sink                         pixel_in,
  input  wire logic                           q_full,
  output logic                                push,
  output rlsfe_pkg::desc_t                    push_desc
);

  logic [rlsfe_pkg::LEN_W-1:0] chain_length;
  logic [7:0]                  brightness_scale;
  logic [7:0]                  pixel_brightness;
  logic [rlsfe_pkg::POS_W-1:0] pixel_position;

  logic [rlsfe_pkg::LEN_W-1:0] len;
  logic [rlsfe_pkg::LEN_W-1:0] len_round;
  logic [rlsfe_pkg::LEN_W-1:0] pos_inc;
  logic                        frame_end;
  logic [7:0]                  bright;

  always_comb begin
    if (chain_length == '0) begin
      len = rlsfe_pkg::LEN_W'(1);
    end else if (chain_length > rlsfe_pkg::LEN_W'(rlsfe_pkg::MAX_LEDS)) begin
      len = rlsfe_pkg::LEN_W'(rlsfe_pkg::MAX_LEDS);
    end else begin
      len = chain_length;
    end
  end

  assign len_round = len + rlsfe_pkg::LEN_W'(15);
  assign pos_inc   = {1'b0, pixel_position} + rlsfe_pkg::LEN_W'(1);
  assign frame_end = (pos_inc >= len);
  assign bright    = (pixel_brightness > rlsfe_pkg::BRIGHT_MAX) ? rlsfe_pkg::BRIGHT_MAX
                                                                 : pixel_brightness;

  assign pixel_in.ready = !q_full;
  assign push           = pixel_in.valid && !q_full;

  always_comb begin
    push_desc.start      = (pixel_position == '0);
    push_desc.fill_count = frame_end ? len_round[rlsfe_pkg::FILL_W+3:4] : '0;
    push_desc.header     = rlsfe_pkg::HEADER_MARK | bright;
    push_desc.prod_blue  = 16'(pixel_in.blue) * 16'(brightness_scale);
    push_desc.prod_green = 16'(pixel_in.green) * 16'(brightness_scale);
    push_desc.prod_red   = 16'(pixel_in.red) * 16'(brightness_scale);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_length     <= rlsfe_pkg::LEN_W'(1);
      brightness_scale <= 8'd255;
      pixel_brightness <= 8'd31;
      pixel_position   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rlsfe_pkg::CFG_CHAIN_LENGTH:     chain_length     <= cfg_data;
          rlsfe_pkg::CFG_BRIGHTNESS_SCALE: brightness_scale <= cfg_data[7:0];
          rlsfe_pkg::CFG_PIXEL_BRIGHTNESS: pixel_brightness <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (push) begin
        pixel_position <= frame_end ? '0 : pos_inc[rlsfe_pkg::POS_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rlsfe_queue.sv */
// ----------------------------------------------------------------------------
// Frame encoder entry queue
// Short first-in first-out queue of classified pixels between the two ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rlsfe_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rlsfe_pkg::desc_t  push_desc,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output rlsfe_pkg::desc_t       head
);

  rlsfe_pkg::desc_t             entries [rlsfe_pkg::QDEPTH];
  logic [rlsfe_pkg::QPTR_W-1:0] wr_ptr;
  logic [rlsfe_pkg::QPTR_W-1:0] rd_ptr;
  logic [rlsfe_pkg::QCNT_W-1:0] fill;
  logic                         do_pop;

  assign full       = (fill == rlsfe_pkg::QCNT_W'(rlsfe_pkg::QDEPTH));
  assign head_valid = (fill != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rlsfe_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + rlsfe_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) begin
        fill <= fill + rlsfe_pkg::QCNT_W'(1);
      end else if (do_pop && !push) begin
        fill <= fill - rlsfe_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rlsfe_back.sv */
// ----------------------------------------------------------------------------
// Frame encoder back end
// Walks each queue entry byte by byte: start frame, header, colours and end
// frame, into a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module rlsfe_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire rlsfe_pkg::desc_t head,
  output logic                  pop,
  rlsfe_byte_if.source          byte_out
);

  typedef enum logic [2:0] {
    ST_LEAD,
    ST_HDR,
    ST_BLUE,
    ST_GREEN,
    ST_RED,
    ST_FILL
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [rlsfe_pkg::FILL_W-1:0] cnt;
  logic [rlsfe_pkg::FILL_W-1:0] cnt_next;
  logic [rlsfe_pkg::FILL_W-1:0] cnt_inc;
  logic                         out_valid;
  logic [7:0]                   out_byte;
  logic                         out_last;
  logic                         take;
  logic [7:0]                   byte_sel;
  logic                         last_sel;

  assign take    = head_valid && (!out_valid || byte_out.ready);
  assign cnt_inc = cnt + rlsfe_pkg::FILL_W'(1);
  assign pop     = take && last_sel;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    byte_sel   = rlsfe_pkg::ZERO_BYTE;
    last_sel   = 1'b0;
    case (state)
      ST_LEAD: begin
        if (head.start) begin
          byte_sel = rlsfe_pkg::ZERO_BYTE;
          if (cnt[1:0] == rlsfe_pkg::START_LAST) begin
            state_next = ST_HDR;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt_inc;
          end
        end else begin
          byte_sel   = head.header;
          state_next = ST_BLUE;
        end
      end
      ST_HDR: begin
        byte_sel   = head.header;
        state_next = ST_BLUE;
      end
      ST_BLUE: begin
        byte_sel   = rlsfe_pkg::div255(head.prod_blue);
        state_next = ST_GREEN;
      end
      ST_GREEN: begin
        byte_sel   = rlsfe_pkg::div255(head.prod_green);
        state_next = ST_RED;
      end
      ST_RED: begin
        byte_sel = rlsfe_pkg::div255(head.prod_red);
        cnt_next = '0;
        if (head.fill_count == '0) begin
          last_sel   = 1'b1;
          state_next = ST_LEAD;
        end else begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        byte_sel = rlsfe_pkg::FILL_BYTE;
        if (cnt_inc == head.fill_count) begin
          last_sel   = 1'b1;
          state_next = ST_LEAD;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      default: begin
        state_next = ST_LEAD;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LEAD;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else if (take) begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= 1'b1;
      out_byte  <= byte_sel;
      out_last  <= last_sel;
    end else if (byte_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign byte_out.valid       = out_valid;
  assign byte_out.serial_byte = out_byte;
  assign byte_out.last_of_run = out_last;

endmodule

`default_nettype wire

/* hw/rtl/rgb_led_strip_frame_encoder.sv */
// ----------------------------------------------------------------------------
// RGB LED strip frame encoder
// Turns a stream of pixels into the byte stream for a clocked RGB LED chain.
// ----------------------------------------------------------------------------
// Pixels enter on pixel_in, one red/green/blue item per handshake, in chain
// order. Bytes leave on byte_out, one per handshake, with last_of_run set on
// the final byte caused by each pixel. The first pixel of a frame is preceded
// by four zero bytes; each pixel gives a header byte and three scaled colour
// bytes; the last pixel of a frame is followed by the end frame of 0xFF bytes.
// The user must write the configuration registers through cfg_we, cfg_index
// and cfg_data only while the block is idle; the block does not enforce this.
// The first byte of a pixel passes through the queue and the output register.
// The output delivers one byte per cycle while the receiver is ready; a pixel
// gives four bytes, plus four for a start frame, and the output byte sequencer
// sets that rate. A four-entry queue lets pixels be taken while earlier ones
// are still being sent. When the receiver stalls, the output byte holds and
// pixels are taken until the queue is full. Reset empties the queue, returns
// to the start of a frame and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_strip_frame_encoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [rlsfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rlsfe_pkg::CFG_W-1:0]     cfg_data,
  rlsfe_pixel_if.sink                          pixel_in,
  rlsfe_byte_if.source                         byte_out
);

  logic             push;
  rlsfe_pkg::desc_t push_desc;
  logic             q_full;
  logic             pop;
  logic             head_valid;
  rlsfe_pkg::desc_t head;

  rlsfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_in),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  rlsfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rlsfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .byte_out   (byte_out)
  );

endmodule

`default_nettype wire

/* tb/sv/rgb_led_strip_frame_encoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED strip frame encoder testbench
// Feeds pixels in random bursts and stalls the byte output on its own pattern.
// Every byte and its run marker are checked against a frame encoder kept in
// the bench, across several register settings that include the extremes.
// ----------------------------------------------------------------------------
module rgb_led_strip_frame_encoder_tb;
  import rlsfe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int START_LEN  = 4;
  localparam int REPORT_MAX = 10;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 45;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } led_byte_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rlsfe_pixel_if pix ();
  rlsfe_byte_if  bout ();

  rgb_led_strip_frame_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pix),
    .byte_out  (bout)
  );

  pixel_t    pixel_q[$];
  led_byte_t led_byte_q[$];

  logic [LEN_W-1:0] chain_len_reg;
  logic [7:0]       global_gain;
  logic [7:0]       led_bright;
  int unsigned      frame_pos;

  int unsigned pixels_offered;
  int unsigned pixels_taken;
  int          fail_count;
  bit          tx_gaps;
  int          rx_mode;
  int          burst_left;
  int          gap_left;
  int          rx_run;
  pixel_t      next_px;
  led_byte_t   want;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] scale_color(input logic [7:0] c);
    int unsigned prod;
    prod = c * global_gain;
    return 8'(prod / 255);
  endfunction

  function automatic void encode_pixel(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    int unsigned len;
    int unsigned fill;
    led_byte_t   run[$];
    led_byte_t   item;
    len = chain_len_reg;
    if (len == 0) len = 1;
    if (len > MAX_LEDS) len = MAX_LEDS;
    if (frame_pos == 0) begin
      repeat (START_LEN) run.push_back('{ZERO_BYTE, 1'b0});
    end
    run.push_back('{HEADER_MARK | ((led_bright > BRIGHT_MAX) ? BRIGHT_MAX : led_bright), 1'b0});
    run.push_back('{scale_color(b), 1'b0});
    run.push_back('{scale_color(g), 1'b0});
    run.push_back('{scale_color(r), 1'b0});
    if (frame_pos + 1 >= len) begin
      fill = (len + 15) / 16;
      repeat (fill) run.push_back('{FILL_BYTE, 1'b0});
      frame_pos = 0;
    end else begin
      frame_pos = (frame_pos + 1) % MAX_LEDS;
    end
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) begin
      item = run[i];
      led_byte_q.push_back(item);
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    case (idx)
      CFG_CHAIN_LENGTH:     chain_len_reg = LEN_W'(value);
      CFG_BRIGHTNESS_SCALE: global_gain   = 8'(value);
      CFG_PIXEL_BRIGHTNESS: led_bright    = 8'(value);
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_q.push_back('{r, g, b});
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || pixels_taken != pixels_offered || led_byte_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (pix.valid && pixels_taken != pixels_offered) begin
    end else if (gap_left > 0) begin
      gap_left--;
      pix.valid <= 1'b0;
    end else if (pixel_q.size() > 0) begin
      next_px = pixel_q.pop_front();
      pix.red   <= next_px.red;
      pix.green <= next_px.green;
      pix.blue  <= next_px.blue;
      pix.valid <= 1'b1;
      pixels_offered++;
      if (burst_left > 0) begin
        burst_left--;
      end else if (tx_gaps) begin
        burst_left = $urandom_range(0, 11);
        gap_left   = $urandom_range(1, 6);
      end
    end else begin
      pix.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      bout.ready <= 1'b0;
    end else if (rx_mode == 0) begin
      bout.ready <= 1'b1;
    end else if (rx_run > 0) begin
      rx_run--;
    end else if (bout.ready) begin
      bout.ready <= 1'b0;
      rx_run = (rx_mode == 1) ? $urandom_range(0, 3) : $urandom_range(2, 11);
    end else begin
      bout.ready <= 1'b1;
      rx_run = (rx_mode == 1) ? $urandom_range(0, 7) : $urandom_range(0, 1);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (bout.valid && bout.ready) begin
        if (led_byte_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected byte: got %h last %b", bout.serial_byte, bout.last_of_run);
        end else begin
          want = led_byte_q.pop_front();
          if (bout.serial_byte !== want.data || bout.last_of_run !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("byte mismatch: expected %h last %b, got %h last %b",
                       want.data, want.last, bout.serial_byte, bout.last_of_run);
          end
        end
      end
      if (pix.valid && pix.ready) begin
        encode_pixel(pix.red, pix.green, pix.blue);
        pixels_taken++;
      end
    end
  end

  initial begin
    #10ms;
    $display("rgb_led_strip_frame_encoder_tb NOT OK");
    $finish;
  end

  initial begin
    int unsigned len;
    int unsigned gain;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = CFG_CHAIN_LENGTH;
    cfg_data   = '0;
    pix.valid  = 1'b0;
    pix.red    = '0;
    pix.green  = '0;
    pix.blue   = '0;
    bout.ready = 1'b0;
    tx_gaps    = 1'b0;
    rx_mode    = 0;
    chain_len_reg = LEN_W'(1);
    global_gain   = 8'd255;
    led_bright    = 8'd31;
    frame_pos     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_pixel(8'h00, 8'h00, 8'h00);
    add_pixel(8'hFF, 8'hFF, 8'hFF);
    add_pixel(8'h5A, 8'hA5, 8'h01);
    drain();

    // A zero length behaves as a single LED; zero gain blanks every colour.
    write_reg(CFG_CHAIN_LENGTH, 0);
    write_reg(CFG_BRIGHTNESS_SCALE, 0);
    write_reg(CFG_PIXEL_BRIGHTNESS, 0);
    add_pixel(8'hFF, 8'hFF, 8'hFF);
    add_pixel(8'h01, 8'h02, 8'h03);
    drain();

    write_reg(CFG_CHAIN_LENGTH, 3);
    write_reg(CFG_BRIGHTNESS_SCALE, 1);
    write_reg(CFG_PIXEL_BRIGHTNESS, 255);
    add_pixel(8'hFF, 8'h00, 8'hFF);
    add_pixel(8'h00, 8'hFF, 8'h00);
    add_pixel(8'hAA, 8'h55, 8'h01);
    add_pixel(8'hFE, 8'h80, 8'h7F);
    drain();

    // Shorten the chain part way through a frame, and write bits beyond the
    // register widths and to an index that has no register.
    write_reg(CFG_CHAIN_LENGTH, 1);
    write_reg(CFG_BRIGHTNESS_SCALE, 10'h3FE);
    write_reg(CFG_PIXEL_BRIGHTNESS, 10'h320);
    write_reg(CFG_UNMAPPED, 10'h3FF);
    add_pixel(8'h80, 8'h40, 8'h20);
    add_pixel(8'h10, 8'h08, 8'h04);
    drain();

    write_reg(CFG_CHAIN_LENGTH, 10'h3FF);
    write_reg(CFG_BRIGHTNESS_SCALE, 10'h180);
    write_reg(CFG_PIXEL_BRIGHTNESS, 30);
    add_pixel(8'hFF, 8'h7F, 8'h00);
    add_pixel(8'h02, 8'hFD, 8'h81);
    add_pixel(8'hC3, 8'h3C, 8'hE7);
    drain();

    write_reg(CFG_CHAIN_LENGTH, 2);
    add_pixel(8'h11, 8'h22, 8'h33);
    add_pixel(8'hEE, 8'hDD, 8'hCC);
    drain();

    write_reg(CFG_CHAIN_LENGTH, MAX_LEDS);
    write_reg(CFG_BRIGHTNESS_SCALE, 255);
    write_reg(CFG_PIXEL_BRIGHTNESS, 31);
    add_pixel(8'h01, 8'h80, 8'hFE);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      tx_gaps = (ph % 4) != 0;
      rx_mode = ph % 3;
      case (ph)
        3:       len = 0;
        5:       len = $urandom_range(MAX_LEDS + 1, 1023);
        6:       len = $urandom_range(25, 120);
        default: len = $urandom_range(1, 24);
      endcase
      case (ph)
        1:       gain = 0;
        2:       gain = 255;
        default: gain = $urandom_range(0, 1023);
      endcase
      write_reg(CFG_CHAIN_LENGTH, len);
      write_reg(CFG_BRIGHTNESS_SCALE, gain);
      write_reg(CFG_PIXEL_BRIGHTNESS, $urandom_range(0, 1023));
      if ($urandom_range(0, 1) == 1)
        write_reg(CFG_UNMAPPED, $urandom_range(0, 1023));
      repeat (PHASE_LEN)
        add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      drain();
    end

    repeat (16) @(posedge clk);
    fail_count += led_byte_q.size();
    if (fail_count == 0) begin
      $display("rgb_led_strip_frame_encoder_tb OK");
    end else begin
      $display("rgb_led_strip_frame_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule

/* rgb_led_strip_frame_encoder.f */
hw/rtl/rlsfe_pkg.sv
hw/rtl/rlsfe_pixel_if.sv
hw/rtl/rlsfe_byte_if.sv
hw/rtl/rlsfe_front.sv
hw/rtl/rlsfe_queue.sv
hw/rtl/rlsfe_back.sv
hw/rtl/rgb_led_strip_frame_encoder.sv
tb/sv/rgb_led_strip_frame_encoder_tb.sv
